// ===== hw/rtl/gprb_pkg.sv =====
// Package for the GPIO port register block: register word map, size codes,
// controller state and command types. No dependencies.
`timescale 1ns / 1ps

package gprb_pkg;

    // Default watched pin for the input data register mirror
    localparam int GPRB_WATCHED_PIN_DEF = 10;

    // Access size codes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Word indexes within the port window (offset bits 9..2)
    localparam logic [7:0] W_MODER   = 8'd0;
    localparam logic [7:0] W_OTYPER  = 8'd1;
    localparam logic [7:0] W_OSPEEDR = 8'd2;
    localparam logic [7:0] W_PUPDR   = 8'd3;
    localparam logic [7:0] W_IDR     = 8'd4;
    localparam logic [7:0] W_ODR     = 8'd5;
    localparam logic [7:0] W_BSRR    = 8'd6;
    localparam logic [7:0] W_LCKR    = 8'd7;
    localparam logic [7:0] W_AFRL    = 8'd8;
    localparam logic [7:0] W_AFRH    = 8'd9;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } t_ctl_state;

    // Command from controller to datapath
    typedef struct packed {
        logic load;   // capture the access, update state, register the result
    } t_dp_cmd;

    // Byte or halfword mask, word access keeps all bits
    function automatic logic [31:0] size_mask(input logic [1:0] sz);
        logic [31:0] m;
        m = 32'hFFFF_FFFF;
        if (sz == SZ_BYTE) begin
            m = 32'h0000_00FF;
        end else if (sz == SZ_HALF) begin
            m = 32'h0000_FFFF;
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/gprb_ctrl.sv =====
// Controller for the GPIO port register block: tracks the result register
// and drives the stream handshakes. Depends on gprb_pkg.
`timescale 1ns / 1ps

module gprb_ctrl
    import gprb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_in_ready  = (r_state == ST_EMPTY) || i_out_ready;
        o_out_valid = (r_state == ST_FULL);
        o_cmd.load  = i_in_valid && o_in_ready;
        n_state     = r_state;
        unique case (r_state)
            ST_EMPTY: begin
                if (o_cmd.load) n_state = ST_FULL;
            end
            ST_FULL: begin
                if (o_cmd.load) begin
                    n_state = ST_FULL;
                end else if (i_out_ready) begin
                    n_state = ST_EMPTY;
                end
            end
            default: n_state = ST_EMPTY;
        endcase
    end

    // An accepted access always produces a result in the next cycle
    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_out_valid)
        else $error("accepted access did not produce a result");

    // A taken result with no new access leaves the result register empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_cmd.load) |=> !o_out_valid)
        else $error("result repeated after being taken");

    // An empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

// ===== hw/rtl/gprb_datapath.sv =====
// Datapath for the GPIO port register block: port registers, lane read and
// merge logic, and the result register. Depends on gprb_pkg.
`timescale 1ns / 1ps

module gprb_datapath
    import gprb_pkg::*;
#(
    parameter int WATCHED_PIN = GPRB_WATCHED_PIN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic        i_opcode,
    input  logic [9:0]  i_offset,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_write_data,
    output logic [31:0] o_read_data,
    output logic        o_pin_level
);

    logic [31:0] r_mode;
    logic [15:0] r_otype;
    logic [31:0] r_speed;
    logic [31:0] r_pull;
    logic        r_mirror;
    logic [15:0] r_odr;
    logic [31:0] r_lock;
    logic [31:0] r_afrl;
    logic [31:0] r_afrh;
    logic [31:0] r_read_data;
    logic        r_pin_level;

    logic [31:0] n_mode;
    logic [15:0] n_otype;
    logic [31:0] n_speed;
    logic [31:0] n_pull;
    logic [15:0] n_odr;
    logic [31:0] n_lock;
    logic [31:0] n_afrl;
    logic [31:0] n_afrh;
    logic [31:0] n_read_data;

    logic [7:0]  word;
    logic [4:0]  shamt;
    logic        is_word;
    logic [31:0] smask;
    logic [31:0] lmask;
    logic [31:0] sel_reg;
    logic        mapped;
    logic [31:0] merged;
    logic [31:0] bsrr_v;

    always_comb begin
        word    = i_offset[9:2];
        shamt   = {i_offset[1:0], 3'b000};
        is_word = i_access_size[1];
        smask   = size_mask(i_access_size);
        lmask   = smask << shamt;

        mapped  = 1'b1;
        unique case (word)
            W_MODER:   sel_reg = r_mode;
            W_OTYPER:  sel_reg = {16'h0000, r_otype};
            W_OSPEEDR: sel_reg = r_speed;
            W_PUPDR:   sel_reg = r_pull;
            W_IDR:     sel_reg = 32'(r_mirror) << WATCHED_PIN;
            W_ODR:     sel_reg = {16'h0000, r_odr};
            W_LCKR:    sel_reg = r_lock;
            W_AFRL:    sel_reg = r_afrl;
            W_AFRH:    sel_reg = r_afrh;
            default: begin
                sel_reg = 32'h0000_0000;
                mapped  = 1'b0;
            end
        endcase

        merged = is_word ? i_write_data
                         : (sel_reg & ~lmask) | ((i_write_data << shamt) & lmask);
        bsrr_v = is_word ? i_write_data : ((i_write_data & smask) << shamt);

        n_mode  = r_mode;
        n_otype = r_otype;
        n_speed = r_speed;
        n_pull  = r_pull;
        n_odr   = r_odr;
        n_lock  = r_lock;
        n_afrl  = r_afrl;
        n_afrh  = r_afrh;
        n_read_data = 32'h0000_0000;

        if (i_opcode == OP_WRITE) begin
            unique case (word)
                W_MODER:   n_mode  = merged;
                W_OTYPER:  n_otype = merged[15:0];
                W_OSPEEDR: n_speed = merged;
                W_PUPDR:   n_pull  = merged;
                W_ODR:     n_odr   = merged[15:0];
                // set half wins over reset half for the same pin
                W_BSRR:    n_odr   = (r_odr & ~bsrr_v[31:16]) | bsrr_v[15:0];
                W_LCKR:    n_lock  = merged;
                W_AFRL:    n_afrl  = merged;
                W_AFRH:    n_afrh  = merged;
                default:   n_odr   = r_odr;
            endcase
        end else if (mapped) begin
            n_read_data = is_word ? sel_reg : ((sel_reg >> shamt) & smask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_otype  <= '0;
            r_speed  <= '0;
            r_pull   <= '0;
            r_mirror <= 1'b0;
            r_odr    <= '0;
            r_lock   <= '0;
            r_afrl   <= '0;
            r_afrh   <= '0;
        end else if (i_cmd.load) begin
            r_mode   <= n_mode;
            r_otype  <= n_otype;
            r_speed  <= n_speed;
            r_pull   <= n_pull;
            r_mirror <= n_odr[WATCHED_PIN];
            r_odr    <= n_odr;
            r_lock   <= n_lock;
            r_afrl   <= n_afrl;
            r_afrh   <= n_afrh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_read_data <= n_read_data;
            r_pin_level <= n_odr[WATCHED_PIN];
        end
    end

    assign o_read_data = r_read_data;
    assign o_pin_level = r_pin_level;

endmodule

// ===== hw/rtl/gpio_port_register_block.sv =====
// A result is registered and is valid in the cycle after its access is accepted.
// One access per cycle while each result is taken; the single result register sets this,
// and a new access is taken in the same cycle the held result is taken.
// Reset (i_rst_n low, synchronous): all port registers and the pin mirror
// clear to zero and the result register empties.
// Top level of the GPIO port register block; uses gprb_pkg, gprb_ctrl, gprb_datapath.
`timescale 1ns / 1ps

module gpio_port_register_block
    import gprb_pkg::*;
#(
    parameter int WATCHED_PIN = GPRB_WATCHED_PIN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Access in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [9:0] offset, [11:10] access_size,
                                       // [43:12] write_data, [47:44] zero
    input  logic        s_axis_tuser,  // [0] opcode (0 read, 1 write)
    // Result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // [31:0] read_data, [32] pin_level,
                                       // [39:33] zero
);

    t_dp_cmd     cmd;
    logic [31:0] read_data;
    logic        pin_level;

    // Controller: hold the result until taken, accept when the slot frees up
    gprb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    // Datapath: decode the word, merge writes, shift and mask reads
    gprb_datapath #(
        .WATCHED_PIN (WATCHED_PIN)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (s_axis_tuser),
        .i_offset      (s_axis_tdata[9:0]),
        .i_access_size (s_axis_tdata[11:10]),
        .i_write_data  (s_axis_tdata[43:12]),
        .o_read_data   (read_data),
        .o_pin_level   (pin_level)
    );

    // Pack the result, pad to whole bytes
    assign m_axis_tdata = {7'b0000000, pin_level, read_data};

endmodule
